// ===== src/pcc_pkg.sv =====
// pcc_pkg: shared types, constants and the arctangent table of the
// polar / rectangular converter. No dependencies.
package pcc_pkg;

    localparam int PCC_ITERATIONS   = 16;
    localparam int PCC_DATA_WIDTH   = 16;
    localparam int PCC_COORD_WIDTH  = 16;
    localparam int PCC_RADIUS_WIDTH = 15;
    localparam int PCC_Z_WIDTH      = 26;
    localparam int PCC_ATAN_ENTRIES = 24;

    localparam int PCC_ANGLE_SHIFT  = 9;
    localparam int PCC_HALF_TURN    = 23040;
    localparam int PCC_FULL_TURN    = 46080;
    localparam int PCC_QUARTER_INT  = 5898240;
    localparam int PCC_OUT_MAX_S    = 32767;
    localparam int PCC_OUT_MAX_U    = 65535;

    localparam logic signed [30:0] PCC_GAIN_Q30 = 31'sd652032874;

    // round(atan(2^-i) * 180/pi * 2^16)
    localparam int PCC_ATAN_TAB [PCC_ATAN_ENTRIES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic cmd;
        logic vec_zero;
    } pcc_ctl_t;

endpackage

// ===== src/pcc_prep.sv =====
// pcc_prep: angle reduction, gain pre-scaling and quadrant setup,
// three pipeline stages in front of the rotation cells. Uses pcc_pkg.
module pcc_prep #(
    parameter int unsigned DATA_WIDTH = pcc_pkg::PCC_DATA_WIDTH,
    parameter int unsigned W          = pcc_pkg::PCC_COORD_WIDTH + DATA_WIDTH + 3
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        cmd,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  x_in,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  y_in,
    input  logic        [pcc_pkg::PCC_RADIUS_WIDTH-1:0] radius_in,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  angle_in,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output pcc_pkg::pcc_ctl_t                           out_ctl,
    output logic signed [W-1:0]                         out_x,
    output logic signed [W-1:0]                         out_y,
    output logic signed [pcc_pkg::PCC_Z_WIDTH-1:0]      out_z
);
    import pcc_pkg::*;

    localparam int ZW  = PCC_Z_WIDTH;
    localparam int CW  = PCC_COORD_WIDTH;
    localparam int PW  = CW + 31;
    localparam int SHL = (DATA_WIDTH >= 30) ? int'(DATA_WIDTH) - 30 : 0;
    localparam int SHR = (DATA_WIDTH < 30) ? 30 - int'(DATA_WIDTH) : 0;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(PCC_QUARTER_INT);

    typedef enum logic [1:0] {
        QUAD_NONE = 2'd0,
        QUAD_POS  = 2'd1,
        QUAD_NEG  = 2'd2
    } quad_t;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    assign r3        = !v3_reg || out_ready;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v3_reg;

    // stage 1: angle reduction and quadrant choice
    logic signed [CW:0]   a_wide, a_red;
    logic signed [ZW-1:0] z_full;
    logic signed [ZW-1:0] z1_next, z1_reg;
    quad_t                quad1_next, quad1_reg;
    pcc_ctl_t             ctl1_next, ctl1_reg;
    logic signed [CW-1:0] ma1_next, ma1_reg, mb1_reg;

    always_comb
    begin
        a_wide = (CW + 1)'(angle_in);
        if (a_wide > (CW + 1)'(PCC_HALF_TURN))
        begin
            a_red = a_wide - (CW + 1)'(PCC_FULL_TURN);
        end
        else if (a_wide < -(CW + 1)'(PCC_HALF_TURN))
        begin
            a_red = a_wide + (CW + 1)'(PCC_FULL_TURN);
        end
        else
        begin
            a_red = a_wide;
        end
        z_full = ZW'(a_red) <<< PCC_ANGLE_SHIFT;

        if (!cmd)
        begin
            if (z_full > QUARTER)
            begin
                quad1_next = QUAD_POS;
                z1_next    = z_full - QUARTER;
            end
            else if (z_full < -QUARTER)
            begin
                quad1_next = QUAD_NEG;
                z1_next    = z_full + QUARTER;
            end
            else
            begin
                quad1_next = QUAD_NONE;
                z1_next    = z_full;
            end
        end
        else
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    quad1_next = QUAD_POS;
                    z1_next    = QUARTER;
                end
                else
                begin
                    quad1_next = QUAD_NEG;
                    z1_next    = -QUARTER;
                end
            end
            else
            begin
                quad1_next = QUAD_NONE;
                z1_next    = '0;
            end
        end

        ctl1_next.cmd      = cmd;
        ctl1_next.vec_zero = cmd && (x_in == 0) && (y_in == 0);
        ma1_next           = cmd ? x_in : signed'({1'b0, radius_in});
    end

    // stage 2: gain pre-scaling
    logic signed [PW-1:0] prod_a, prod_b;
    logic signed [63:0]   wide_a, wide_b;
    logic signed [W-1:0]  sa_next, sb_next, sa_reg, sb_reg;
    logic signed [ZW-1:0] z2_reg;
    quad_t                quad2_reg;
    pcc_ctl_t             ctl2_reg;

    always_comb
    begin
        prod_a  = PW'(ma1_reg) * PW'(PCC_GAIN_Q30);
        prod_b  = PW'(mb1_reg) * PW'(PCC_GAIN_Q30);
        wide_a  = 64'(prod_a);
        wide_b  = 64'(prod_b);
        sa_next = W'((wide_a <<< SHL) >>> SHR);
        sb_next = W'((wide_b <<< SHL) >>> SHR);
    end

    // stage 3: start vector
    logic signed [W-1:0] x3_next, y3_next;

    always_comb
    begin
        unique case (quad2_reg)
            QUAD_NONE:
            begin
                x3_next = sa_reg;
                y3_next = ctl2_reg.cmd ? sb_reg : '0;
            end
            QUAD_POS:
            begin
                x3_next = ctl2_reg.cmd ? sb_reg : '0;
                y3_next = ctl2_reg.cmd ? -sa_reg : sa_reg;
            end
            QUAD_NEG:
            begin
                x3_next = ctl2_reg.cmd ? -sb_reg : '0;
                y3_next = ctl2_reg.cmd ? sa_reg : -sa_reg;
            end
            default:
            begin
                x3_next = '0;
                y3_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            z1_reg    <= z1_next;
            quad1_reg <= quad1_next;
            ctl1_reg  <= ctl1_next;
            ma1_reg   <= ma1_next;
            mb1_reg   <= y_in;
        end
        if (v1_reg && r2)
        begin
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
            z2_reg    <= z1_reg;
            quad2_reg <= quad1_reg;
            ctl2_reg  <= ctl1_reg;
        end
        if (v2_reg && r3)
        begin
            out_x   <= x3_next;
            out_y   <= y3_next;
            out_z   <= z2_reg;
            out_ctl <= ctl2_reg;
        end
    end

endmodule

// ===== src/pcc_cell.sv =====
// pcc_cell: one micro-rotation stage of the cordic chain, rotation or
// vectoring chosen per request. Uses pcc_pkg.
module pcc_cell #(
    parameter int unsigned W     = pcc_pkg::PCC_COORD_WIDTH + pcc_pkg::PCC_DATA_WIDTH + 3,
    parameter int unsigned STAGE = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  pcc_pkg::pcc_ctl_t                      in_ctl,
    input  logic signed [W-1:0]                    in_x,
    input  logic signed [W-1:0]                    in_y,
    input  logic signed [pcc_pkg::PCC_Z_WIDTH-1:0] in_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output pcc_pkg::pcc_ctl_t                      out_ctl,
    output logic signed [W-1:0]                    out_x,
    output logic signed [W-1:0]                    out_y,
    output logic signed [pcc_pkg::PCC_Z_WIDTH-1:0] out_z
);
    import pcc_pkg::*;

    localparam int ZW = PCC_Z_WIDTH;
    localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(PCC_ATAN_TAB[STAGE]);

    logic                 valid_reg;
    logic                 up;
    logic signed [W-1:0]  dx, dy, x_next, y_next;
    logic signed [ZW-1:0] z_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        up = in_ctl.cmd ? (in_y < 0) : (in_z >= 0);
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (up)
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_STEP;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            out_ctl <= in_ctl;
            out_x   <= x_next;
            out_y   <= y_next;
            out_z   <= z_next;
        end
    end

endmodule

// ===== src/pcc_post.sv =====
// pcc_post: rounding to Q8.8 and 1/128 degree, saturation and the output
// register of the converter. Uses pcc_pkg.
module pcc_post #(
    parameter int unsigned DATA_WIDTH = pcc_pkg::PCC_DATA_WIDTH,
    parameter int unsigned W          = pcc_pkg::PCC_COORD_WIDTH + DATA_WIDTH + 3
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  pcc_pkg::pcc_ctl_t                          in_ctl,
    input  logic signed [W-1:0]                        in_x,
    input  logic signed [W-1:0]                        in_y,
    input  logic signed [pcc_pkg::PCC_Z_WIDTH-1:0]     in_z,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0] x_out,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0] y_out,
    output logic        [pcc_pkg::PCC_COORD_WIDTH-1:0] radius_out,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0] angle_out
);
    import pcc_pkg::*;

    localparam int ZW = PCC_Z_WIDTH;
    localparam int CW = PCC_COORD_WIDTH;
    localparam logic signed [W-1:0]  ROUND  = W'(64'sd1 <<< (DATA_WIDTH - 1));
    localparam logic signed [W-1:0]  SMAX   = W'(PCC_OUT_MAX_S);
    localparam logic signed [W-1:0]  UMAX   = W'(PCC_OUT_MAX_U);
    localparam logic signed [ZW-1:0] ZROUND = ZW'(1 <<< (PCC_ANGLE_SHIFT - 1));
    localparam logic signed [ZW-1:0] AMAX   = ZW'(PCC_HALF_TURN);

    logic                 valid_reg;
    logic signed [W-1:0]  xq, yq, xs, ys, rs;
    logic signed [ZW-1:0] zq, zs;
    logic signed [CW-1:0] x_next, y_next, a_next;
    logic        [CW-1:0] r_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        xq = (in_x + ROUND) >>> DATA_WIDTH;
        yq = (in_y + ROUND) >>> DATA_WIDTH;
        zq = (in_z + ZROUND) >>> PCC_ANGLE_SHIFT;

        xs = (xq > SMAX) ? SMAX : ((xq < -SMAX) ? -SMAX : xq);
        ys = (yq > SMAX) ? SMAX : ((yq < -SMAX) ? -SMAX : yq);
        rs = (xq > UMAX) ? UMAX : ((xq < 0) ? '0 : xq);
        zs = (zq > AMAX) ? AMAX : ((zq < -AMAX) ? -AMAX : zq);

        if (!in_ctl.cmd)
        begin
            x_next = xs[CW-1:0];
            y_next = ys[CW-1:0];
            r_next = '0;
            a_next = '0;
        end
        else if (in_ctl.vec_zero)
        begin
            x_next = '0;
            y_next = '0;
            r_next = '0;
            a_next = '0;
        end
        else
        begin
            x_next = '0;
            y_next = '0;
            r_next = rs[CW-1:0];
            a_next = zs[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_out      <= x_next;
            y_out      <= y_next;
            radius_out <= r_next;
            angle_out  <= a_next;
        end
    end

endmodule

// ===== src/polar_cartesian_convert.sv =====
// Polar / rectangular converter built on a pipelined cordic chain. One request
// enters per clock cycle unless the chain is stalled, and each request passes three
// front stages (angle reduction, gain pre-scaling, start vector), one cell per
// micro-rotation, and the rounding and output register.
// Every stage holds its own request, so in_ready drops only when the output is
// stalled and no empty stage is left in the chain. cmd 0 gives x and y from
// radius and angle, cmd 1 gives radius and a full-quadrant angle from x and y;
// the fields of the other direction read zero. Angles are degrees in units of
// 1/128. Depends on pcc_pkg, pcc_prep, pcc_cell and pcc_post.
module polar_cartesian_convert #(
    parameter int unsigned ITERATIONS = pcc_pkg::PCC_ITERATIONS,
    parameter int unsigned DATA_WIDTH = pcc_pkg::PCC_DATA_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        cmd,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  x_in,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  y_in,
    input  logic        [pcc_pkg::PCC_RADIUS_WIDTH-1:0] radius_in,
    input  logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  angle_in,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  x_out,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  y_out,
    output logic        [pcc_pkg::PCC_COORD_WIDTH-1:0]  radius_out,
    output logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  angle_out
);
    import pcc_pkg::*;

    localparam int W  = PCC_COORD_WIDTH + int'(DATA_WIDTH) + 3;
    localparam int ZW = PCC_Z_WIDTH;

    logic                 cv [ITERATIONS+1];
    logic                 cr [ITERATIONS+1];
    pcc_ctl_t             cc [ITERATIONS+1];
    logic signed [W-1:0]  cx [ITERATIONS+1];
    logic signed [W-1:0]  cy [ITERATIONS+1];
    logic signed [ZW-1:0] cz [ITERATIONS+1];

    pcc_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .x_in      (x_in),
        .y_in      (y_in),
        .radius_in (radius_in),
        .angle_in  (angle_in),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_ctl   (cc[0]),
        .out_x     (cx[0]),
        .out_y     (cy[0]),
        .out_z     (cz[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_cell
        pcc_cell #(
            .W     (W),
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_ctl    (cc[g]),
            .in_x      (cx[g]),
            .in_y      (cy[g]),
            .in_z      (cz[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_ctl   (cc[g+1]),
            .out_x     (cx[g+1]),
            .out_y     (cy[g+1]),
            .out_z     (cz[g+1])
        );
    end

    pcc_post #(
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cv[ITERATIONS]),
        .in_ready   (cr[ITERATIONS]),
        .in_ctl     (cc[ITERATIONS]),
        .in_x       (cx[ITERATIONS]),
        .in_y       (cy[ITERATIONS]),
        .in_z       (cz[ITERATIONS]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_out      (x_out),
        .y_out      (y_out),
        .radius_out (radius_out),
        .angle_out  (angle_out)
    );

endmodule

// ===== src/pcc_checker.sv =====
// pcc_checker: port-level assertions for polar_cartesian_convert, attached
// by the bind statement at the end of this file. Uses pcc_pkg.
module pcc_checker (
    input logic                                        clk,
    input logic                                        rst_n,
    input logic                                        in_valid,
    input logic                                        in_ready,
    input logic                                        cmd,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  x_in,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  y_in,
    input logic        [pcc_pkg::PCC_RADIUS_WIDTH-1:0] radius_in,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  angle_in,
    input logic                                        out_valid,
    input logic                                        out_ready,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  x_out,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  y_out,
    input logic        [pcc_pkg::PCC_COORD_WIDTH-1:0]  radius_out,
    input logic signed [pcc_pkg::PCC_COORD_WIDTH-1:0]  angle_out
);
    import pcc_pkg::*;

    localparam logic signed [PCC_COORD_WIDTH-1:0] AMAX = PCC_COORD_WIDTH'(PCC_HALF_TURN);
    localparam logic signed [PCC_COORD_WIDTH-1:0] SMIN = PCC_COORD_WIDTH'(-PCC_OUT_MAX_S);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(x_in)
            && $stable(y_in) && $stable(radius_in) && $stable(angle_in))
        else $error("input request changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
            && $stable(radius_out) && $stable(angle_out))
        else $error("result request dropped or changed while stalled");

    // an empty output stage means the whole chain can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_out == 0 && y_out == 0) || (radius_out == 0 && angle_out == 0))
        else $error("fields of both directions set in one result");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_out <= AMAX && angle_out >= -AMAX
            && x_out >= SMIN && y_out >= SMIN)
        else $error("result outside saturation range");

endmodule

bind polar_cartesian_convert pcc_checker u_pcc_checker (.*);
